[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SCC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define SCC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the strongly connected components engine.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned DEF_MAX_NODES = 1024;
  localparam int unsigned DEF_MAX_EDGES = 4096;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NORUN = 2'd3;

  localparam logic [10:0] NODE_COUNT_RST = 11'd1024;

  // Datapath step commanded by the controller
  typedef enum logic [4:0] {
    STEP_IDLE,
    STEP_ACCEPT,
    STEP_SWEEP_LH,
    STEP_SWEEP_RUN,
    STEP_ADD_RD,
    STEP_ADD_WR,
    STEP_Q_RD1,
    STEP_Q_RD2,
    STEP_Q_OUT,
    STEP_R_CHK,
    STEP_R_TST,
    STEP_VISIT,
    STEP_FRAME,
    STEP_LOOP,
    STEP_TOP,
    STEP_EDGE,
    STEP_EDGE2,
    STEP_FIN,
    STEP_POP,
    STEP_POP2,
    STEP_RET,
    STEP_RET2,
    STEP_RET3,
    STEP_DONE
  } step_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] op;
    logic       add_bad;
    logic       store_full;
    logic       run_done;
    logic       q_bad;
    logic       sweep_last;
    logic       root_end;
    logic       root_seen;
    logic       depth_zero;
    logic       depth_gt1;
    logic       edge_live;
    logic       dest_out;
    logic       dest_new;
    logic       root_comp;
    logic       pop_more;
    logic       out_free;
  } stat_t;

endpackage

[rtl/core/scc_ctrl.sv]
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge load, search, query and clear.
// ----------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output step_e cmd_o
);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_ADDR  = 5'd3;
  localparam logic [4:0] S_ADDW  = 5'd4;
  localparam logic [4:0] S_QRD1  = 5'd5;
  localparam logic [4:0] S_QRD2  = 5'd6;
  localparam logic [4:0] S_QOUT  = 5'd7;
  localparam logic [4:0] S_CLR   = 5'd8;
  localparam logic [4:0] S_RSWP  = 5'd9;
  localparam logic [4:0] S_RCHK  = 5'd10;
  localparam logic [4:0] S_RTST  = 5'd11;
  localparam logic [4:0] S_VISIT = 5'd12;
  localparam logic [4:0] S_FRAME = 5'd13;
  localparam logic [4:0] S_LOOP  = 5'd14;
  localparam logic [4:0] S_TOP   = 5'd15;
  localparam logic [4:0] S_EDGE  = 5'd16;
  localparam logic [4:0] S_EDGE2 = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;
  localparam logic [4:0] S_POP   = 5'd19;
  localparam logic [4:0] S_POP2  = 5'd20;
  localparam logic [4:0] S_RET   = 5'd21;
  localparam logic [4:0] S_RET2  = 5'd22;
  localparam logic [4:0] S_RET3  = 5'd23;
  localparam logic [4:0] S_DONE  = 5'd24;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = STEP_IDLE;
    unique case (state_q)
      S_INIT: begin
        cmd_o = STEP_SWEEP_LH;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = STEP_ACCEPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.op)
          OP_ADD:   state_d = S_ADDR;
          OP_RUN:   state_d = S_RSWP;
          OP_QUERY: state_d = S_QRD1;
          default:  state_d = S_CLR;
        endcase
      end
      S_ADDR: begin
        cmd_o   = STEP_ADD_RD;
        state_d = (stat_i.add_bad || stat_i.store_full) ? S_DONE : S_ADDW;
      end
      S_ADDW: begin
        cmd_o   = STEP_ADD_WR;
        state_d = S_DONE;
      end
      S_QRD1: begin
        cmd_o   = STEP_Q_RD1;
        state_d = (!stat_i.run_done || stat_i.q_bad) ? S_DONE : S_QRD2;
      end
      S_QRD2: begin
        cmd_o   = STEP_Q_RD2;
        state_d = S_QOUT;
      end
      S_QOUT: begin
        cmd_o   = STEP_Q_OUT;
        state_d = S_DONE;
      end
      S_CLR: begin
        cmd_o = STEP_SWEEP_LH;
        if (stat_i.sweep_last) state_d = S_DONE;
      end
      S_RSWP: begin
        cmd_o = STEP_SWEEP_RUN;
        if (stat_i.sweep_last) state_d = S_RCHK;
      end
      S_RCHK: begin
        cmd_o   = STEP_R_CHK;
        state_d = stat_i.root_end ? S_DONE : S_RTST;
      end
      S_RTST: begin
        cmd_o   = STEP_R_TST;
        state_d = stat_i.root_seen ? S_RCHK : S_VISIT;
      end
      S_VISIT: begin
        cmd_o   = STEP_VISIT;
        state_d = S_FRAME;
      end
      S_FRAME: begin
        cmd_o   = STEP_FRAME;
        state_d = S_LOOP;
      end
      S_LOOP: begin
        cmd_o   = STEP_LOOP;
        state_d = stat_i.depth_zero ? S_RCHK : S_TOP;
      end
      S_TOP: begin
        cmd_o   = STEP_TOP;
        state_d = stat_i.edge_live ? S_EDGE : S_FIN;
      end
      S_EDGE: begin
        cmd_o   = STEP_EDGE;
        state_d = stat_i.dest_out ? S_LOOP : S_EDGE2;
      end
      S_EDGE2: begin
        cmd_o   = STEP_EDGE2;
        state_d = stat_i.dest_new ? S_VISIT : S_LOOP;
      end
      S_FIN: begin
        cmd_o   = STEP_FIN;
        state_d = stat_i.root_comp ? S_POP : S_RET;
      end
      S_POP: begin
        cmd_o   = STEP_POP;
        state_d = S_POP2;
      end
      S_POP2: begin
        cmd_o   = STEP_POP2;
        state_d = stat_i.pop_more ? S_POP : S_RET;
      end
      S_RET: begin
        cmd_o   = STEP_RET;
        state_d = stat_i.depth_gt1 ? S_RET2 : S_LOOP;
      end
      S_RET2: begin
        cmd_o   = STEP_RET2;
        state_d = S_RET3;
      end
      S_RET3: begin
        cmd_o   = STEP_RET3;
        state_d = S_LOOP;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o   = STEP_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/scc_dp.sv]
// ----------------------------------------------------------------------------
// scc_dp
// Graph memories, search registers and result register.
// ----------------------------------------------------------------------------
module scc_dp import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  step_e       cmd_i,
  output stat_t       stat_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  edge_source_i,
  input  logic [9:0]  edge_target_i,
  input  logic        cfg_valid_i,
  input  logic [10:0] cfg_node_count_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  output logic [9:0]  component_id_o,
  output logic [10:0] component_size_o,
  output logic [10:0] component_count_o
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGES);

  // input item and config
  logic [1:0]    op_q;
  logic [9:0]    src_q, dst_q;
  logic [10:0]   cfg_q;
  logic [CW-1:0] n;

  // control registers
  logic          run_done_q, out_valid_q;
  logic [EW-1:0] edges_q;
  logic [CW-1:0] comps_q, visit_q, sp_q, depth_q, root_q, llu_q, cnt_q;
  logic [NW-1:0] sw_q, x_q, u_q, v_q, p_q;
  logic [1:0]    res_status_q;
  logic [9:0]    res_id_q;
  logic [10:0]   res_size_q, res_count_q;

  // memory read data
  logic [EW-1:0] lh_rd, el_rd, fe_rd;
  logic [NW-1:0] ed_rd, ns_rd, fn_rd, co_rd;
  logic [CW-1:0] vn_rd, ll_rd, cs_rd;
  logic          os_rd;

  logic [EW-1:0] lh_mem [MAX_NODES];
  logic [NW-1:0] ed_mem [MAX_EDGES];
  logic [EW-1:0] el_mem [MAX_EDGES];
  logic [CW-1:0] vn_mem [MAX_NODES];
  logic [CW-1:0] ll_mem [MAX_NODES];
  logic          os_mem [MAX_NODES];
  logic [NW-1:0] ns_mem [MAX_NODES];
  logic [NW-1:0] fn_mem [MAX_NODES];
  logic [EW-1:0] fe_mem [MAX_NODES];
  logic [NW-1:0] co_mem [MAX_NODES];
  logic [CW-1:0] cs_mem [MAX_NODES];

  logic          lh_we, ed_we, vn_we, ll_we, os_we, ns_we, fn_we, fe_we, co_we, cs_we;
  logic [NW-1:0] lh_wa, lh_ra, vn_wa, vn_ra, ll_wa, ll_ra, os_wa, ns_wa, ns_ra;
  logic [NW-1:0] fn_wa, fe_wa, fr_ra, co_wa, co_ra, cs_wa, cs_ra;
  logic [AW-1:0] ed_wa, ed_ra;
  logic [EW-1:0] lh_wd, fe_wd;
  logic [CW-1:0] vn_wd, ll_wd, cs_wd, fr_idx;
  logic          os_wd, ll_lower;

  assign n = (32'(cfg_q) > MAX_NODES) ? CW'(MAX_NODES) : CW'(cfg_q);

  always_comb begin
    stat_o.op         = op_q;
    stat_o.add_bad    = (32'(src_q) >= 32'(n)) || (32'(dst_q) >= 32'(n));
    stat_o.store_full = (32'(edges_q) >= MAX_EDGES);
    stat_o.run_done   = run_done_q;
    stat_o.q_bad      = (32'(src_q) >= 32'(n));
    stat_o.sweep_last = (32'(sw_q) == MAX_NODES - 1);
    stat_o.root_end   = (root_q >= n);
    stat_o.root_seen  = (vn_rd != '0);
    stat_o.depth_zero = (depth_q == '0);
    stat_o.depth_gt1  = (depth_q > CW'(1));
    stat_o.edge_live  = (fe_rd < NO_EDGE);
    stat_o.dest_out   = (32'(ed_rd) >= 32'(n));
    stat_o.dest_new   = (vn_rd == '0);
    stat_o.root_comp  = (ll_rd == vn_rd);
    stat_o.pop_more   = (ns_rd != u_q) && (sp_q != '0);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // back edge to a node still on the stack lowers the current low link
  assign ll_lower = os_rd && (vn_rd < ll_rd);
  assign fr_idx   = (cmd_i == STEP_RET) ? (depth_q - CW'(2)) : (depth_q - CW'(1));

  always_comb begin
    lh_we = 1'b0; lh_wa = x_q; lh_wd = NO_EDGE; lh_ra = x_q;
    ed_we = 1'b0; ed_wa = AW'(edges_q); ed_ra = AW'(fe_rd);
    vn_we = 1'b0; vn_wa = x_q; vn_wd = visit_q + CW'(1); vn_ra = fn_rd;
    ll_we = 1'b0; ll_wa = x_q; ll_wd = visit_q + CW'(1); ll_ra = fn_rd;
    os_we = 1'b0; os_wa = x_q; os_wd = 1'b1;
    ns_we = 1'b0; ns_wa = NW'(sp_q); ns_ra = NW'(sp_q - CW'(1));
    fn_we = 1'b0; fn_wa = NW'(depth_q);
    fe_we = 1'b0; fe_wa = NW'(depth_q); fe_wd = lh_rd;
    fr_ra = NW'(fr_idx);
    co_we = 1'b0; co_wa = ns_rd; co_ra = NW'(src_q);
    cs_we = 1'b0; cs_wa = NW'(comps_q); cs_wd = cnt_q + CW'(1); cs_ra = co_rd;
    unique case (cmd_i)
      STEP_SWEEP_LH: begin
        lh_we = 1'b1; lh_wa = sw_q;
      end
      STEP_SWEEP_RUN: begin
        vn_we = 1'b1; vn_wa = sw_q; vn_wd = '0;
        os_we = 1'b1; os_wa = sw_q; os_wd = 1'b0;
      end
      STEP_ADD_RD: lh_ra = NW'(src_q);
      STEP_ADD_WR: begin
        lh_we = 1'b1; lh_wa = NW'(src_q); lh_wd = edges_q;
        ed_we = 1'b1;
      end
      STEP_R_CHK: vn_ra = NW'(root_q);
      STEP_VISIT: begin
        vn_we = 1'b1;
        ll_we = 1'b1;
        os_we = 1'b1;
        ns_we = (32'(sp_q) < MAX_NODES);
      end
      STEP_FRAME: begin
        fn_we = (32'(depth_q) < MAX_NODES);
        fe_we = (32'(depth_q) < MAX_NODES);
      end
      STEP_EDGE: begin
        fe_we = 1'b1; fe_wa = NW'(depth_q - CW'(1)); fe_wd = el_rd;
        vn_ra = ed_rd;
        ll_ra = u_q;
      end
      STEP_EDGE2: begin
        ll_we = !stat_o.dest_new && ll_lower; ll_wa = u_q; ll_wd = vn_rd;
      end
      STEP_POP2: begin
        os_we = 1'b1; os_wa = ns_rd; os_wd = 1'b0;
        co_we = 1'b1;
        cs_we = !stat_o.pop_more;
      end
      STEP_RET3: begin
        ll_we = (llu_q < ll_rd); ll_wa = p_q; ll_wd = llu_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lh_we) lh_mem[lh_wa] <= lh_wd;
    lh_rd <= lh_mem[lh_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ed_we) begin
      ed_mem[ed_wa] <= NW'(dst_q);
      el_mem[ed_wa] <= lh_rd;
    end
    ed_rd <= ed_mem[ed_ra];
    el_rd <= el_mem[ed_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vn_we) vn_mem[vn_wa] <= vn_wd;
    vn_rd <= vn_mem[vn_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ll_we) ll_mem[ll_wa] <= ll_wd;
    ll_rd <= ll_mem[ll_ra];
  end

  always_ff @(posedge clk_i) begin
    if (os_we) os_mem[os_wa] <= os_wd;
    os_rd <= os_mem[ed_rd];
  end

  always_ff @(posedge clk_i) begin
    if (ns_we) ns_mem[ns_wa] <= x_q;
    ns_rd <= ns_mem[ns_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fn_we) fn_mem[fn_wa] <= x_q;
    if (fe_we) fe_mem[fe_wa] <= fe_wd;
    fn_rd <= fn_mem[fr_ra];
    fe_rd <= fe_mem[fr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (co_we) co_mem[co_wa] <= NW'(comps_q);
    co_rd <= co_mem[co_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) cs_mem[cs_wa] <= cs_wd;
    cs_rd <= cs_mem[cs_ra];
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_i == STEP_ACCEPT) begin
      op_q  <= operation_i;
      src_q <= edge_source_i;
      dst_q <= edge_target_i;
    end
    if (cmd_i == STEP_R_TST) x_q <= NW'(root_q);
    if (cmd_i == STEP_EDGE2) x_q <= v_q;
    if (cmd_i == STEP_TOP)   u_q <= fn_rd;
    if (cmd_i == STEP_EDGE)  v_q <= ed_rd;
    if (cmd_i == STEP_RET2)  p_q <= fn_rd;
    if (cmd_i == STEP_FIN)   llu_q <= ll_rd;
    if (cmd_i == STEP_FIN)   cnt_q <= '0;
    if (cmd_i == STEP_POP2)  cnt_q <= cnt_q + CW'(1);
    if (cmd_i == STEP_DONE) begin
      status_o          <= res_status_q;
      component_id_o    <= res_id_q;
      component_size_o  <= res_size_q;
      component_count_o <= res_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= NODE_COUNT_RST;
      run_done_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      edges_q      <= '0;
      comps_q      <= '0;
      visit_q      <= '0;
      sp_q         <= '0;
      depth_q      <= '0;
      root_q       <= '0;
      sw_q         <= '0;
      res_status_q <= ST_OK;
      res_id_q     <= '0;
      res_size_q   <= '0;
      res_count_q  <= '0;
    end else begin
      if (cmd_i == STEP_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        STEP_ACCEPT: begin
          res_status_q <= ST_OK;
          res_id_q     <= '0;
          res_size_q   <= '0;
          res_count_q  <= '0;
        end
        STEP_SWEEP_LH: begin
          sw_q       <= stat_o.sweep_last ? '0 : sw_q + NW'(1);
          edges_q    <= '0;
          comps_q    <= '0;
          run_done_q <= 1'b0;
        end
        STEP_SWEEP_RUN: begin
          sw_q    <= stat_o.sweep_last ? '0 : sw_q + NW'(1);
          comps_q <= '0;
          visit_q <= '0;
          sp_q    <= '0;
          depth_q <= '0;
          root_q  <= '0;
        end
        STEP_ADD_RD: begin
          if (stat_o.add_bad) res_status_q <= ST_RANGE;
          else if (stat_o.store_full) res_status_q <= ST_FULL;
        end
        STEP_ADD_WR: begin
          edges_q    <= edges_q + EW'(1);
          run_done_q <= 1'b0;
        end
        STEP_Q_RD1: begin
          if (!run_done_q) res_status_q <= ST_NORUN;
          else if (stat_o.q_bad) res_status_q <= ST_RANGE;
        end
        STEP_Q_RD2: res_id_q <= 10'(co_rd);
        STEP_Q_OUT: begin
          res_size_q  <= 11'(cs_rd);
          res_count_q <= 11'(comps_q);
        end
        STEP_R_CHK: begin
          if (stat_o.root_end) begin
            res_count_q <= 11'(comps_q);
            run_done_q  <= 1'b1;
          end
        end
        STEP_R_TST: begin
          if (stat_o.root_seen) root_q <= root_q + CW'(1);
        end
        STEP_VISIT: begin
          visit_q <= visit_q + CW'(1);
          if (32'(sp_q) < MAX_NODES) sp_q <= sp_q + CW'(1);
        end
        STEP_FRAME: begin
          if (32'(depth_q) < MAX_NODES) depth_q <= depth_q + CW'(1);
        end
        STEP_LOOP: begin
          if (stat_o.depth_zero) root_q <= root_q + CW'(1);
        end
        STEP_POP: sp_q <= sp_q - CW'(1);
        STEP_POP2: begin
          if (!stat_o.pop_more) comps_q <= comps_q + CW'(1);
        end
        STEP_RET: depth_q <= depth_q - CW'(1);
        default: ;
      endcase
      if (cfg_valid_i) begin
        cfg_q      <= cfg_node_count_i;
        run_done_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/strongly_connected_components.sv]
// ----------------------------------------------------------------------------
// strongly_connected_components
// Tarjan SCC engine over a loadable directed graph.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item: operation, source,
//   target. Every item returns exactly one item on the output channel
//   (out_valid_o/out_ready_i) carrying status and component results.
//   Config channel (cfg_valid_i/cfg_ready_o) writes node_count; always ready,
//   write only while the engine is idle.
//   A clear sweeps the adjacency heads empty. A run first sweeps the per-node
//   visit and on-stack memories, then walks every node and stored edge in
//   single-port memories, one access each.
//   One item is in work at a time; the next item is taken the cycle after
//   its result is loaded into the output register.
//   Reset: the adjacency heads are swept empty with in_ready_o low. A stalled
//   receiver holds the result in the output register; the engine waits
//   before finishing the following item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strongly_connected_components import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  edge_source_i,
  input  logic [9:0]  edge_target_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_node_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  component_id_o,
  output logic [10:0] component_size_o,
  output logic [10:0] component_count_o
);

  step_e cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scc_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (operation_i),
    .edge_source_i     (edge_source_i),
    .edge_target_i     (edge_target_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_node_count_i  (cfg_node_count_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .component_id_o    (component_id_o),
    .component_size_o  (component_size_o),
    .component_count_o (component_count_o)
  );

  `SCC_ASSERT_NEXT(a_one_item_in_work, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SCC_ASSERT_IMPL(a_error_no_data, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), (component_id_o == '0) && (component_size_o == '0))
  `SCC_ASSERT_IMPL(a_done_slot_free, clk_i, rst_ni, cmd == STEP_DONE, !out_valid_o || out_ready_i)

endmodule
